[sv/bce_pkg.sv]
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types, widths and codes for the battery charge estimator core.
// ----------------------------------------------------------------------------
package bce_pkg;

   // field and state widths
   localparam int CMD_W    = 2;
   localparam int LEFT_W   = 17;
   localparam int SPEED_W  = 16;
   localparam int PCT_W    = 7;
   localparam int DIST_W   = 38;
   localparam int TIME_W   = 22;
   localparam int CHARGE_W = 22;
   localparam int TICKS_W  = 32;
   localparam int TOTAL_W  = TICKS_W + 1;
   localparam int CAP_WH_W = 10;
   localparam int WATT_W   = 8;
   localparam int MIN_W    = 11;
   localparam int FSEC_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // behavior constants
   localparam int TICK_SECONDS    = 2;
   localparam int DRAIN_W         = 14;
   localparam int JOULES_PER_WH   = 3600;
   localparam int SECONDS_PER_MIN = 60;
   localparam int CAP_WH_RESET    = 50;
   localparam int MW_RESET        = 10;
   localparam int SW_RESET        = 5;
   localparam int MIN_RESET       = 120;
   localparam int SPEED_FLOOR     = 250;
   localparam int PCT_MAX         = 100;

   // shared multiplier
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 22;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // shared divider
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 49;
   localparam int DIV_CNT_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 2'd0,
      CMD_CHG_START  = 2'd1,
      CMD_CHG_REPORT = 2'd2,
      CMD_SPEED      = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVING_W     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STANDING_W   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MINUTES = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic               moving;
      logic [LEFT_W-1:0]  remaining_charge_seconds;
      logic [SPEED_W-1:0] avg_speed_mm_s;
   } req_type;

   typedef struct packed {
      logic [PCT_W-1:0]  percent;
      logic [DIST_W-1:0] remaining_distance_mm;
      logic [TIME_W-1:0] remaining_time_s;
      logic              is_charging;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[sv/battery_charge_estimator_core.sv]
// ----------------------------------------------------------------------------
// battery_charge_estimator_core
// Linear battery fuel gauge: drains or recharges the stored charge per word
// and returns percent, remaining distance and remaining time for each word.
//
//   channel  direction  handshake           payload
//   req_     in         req_valid/ready     bce_pkg::req_type
//   rsp_     out        rsp_valid/ready     bce_pkg::rsp_type
//   csr_     in         csr_we              csr_index, csr_wdata
//
// A word runs through the shared divider, one quotient bit per cycle, for
// three divisions: percent, distance and time. A charging tick adds one
// when less than a full charge time is left, a history at least half moving
// five multiplier steps; zero capacity skips the percent division.
// req_ready is high only in idle; a result held by rsp_ready stalls the next
// word at its end. Synchronous active-high reset loads defaults, a full battery.
// ----------------------------------------------------------------------------
module battery_charge_estimator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bce_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bce_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [bce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bce_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bce_pkg::*;

   localparam int CHG_STEPS  = 39;
   localparam int PCT_STEPS  = 29;
   localparam int DIST_STEPS = 38;
   localparam int TIME_STEPS = 63;
   localparam int SPLIT      = 21;

   typedef enum logic [18:0] {
      ST_IDLE     = 19'b000_0000_0000_0000_0001,
      ST_UPDATE   = 19'b000_0000_0000_0000_0010,
      ST_CHG_DIV  = 19'b000_0000_0000_0000_0100,
      ST_PCT_MUL  = 19'b000_0000_0000_0000_1000,
      ST_PCT_DIV  = 19'b000_0000_0000_0001_0000,
      ST_DIST_MUL = 19'b000_0000_0000_0010_0000,
      ST_DIST_DIV = 19'b000_0000_0000_0100_0000,
      ST_TIME_SEL = 19'b000_0000_0000_1000_0000,
      ST_SA       = 19'b000_0000_0001_0000_0000,
      ST_SB       = 19'b000_0000_0010_0000_0000,
      ST_LA       = 19'b000_0000_0100_0000_0000,
      ST_LB       = 19'b000_0000_1000_0000_0000,
      ST_LC       = 19'b000_0001_0000_0000_0000,
      ST_LD       = 19'b000_0010_0000_0000_0000,
      ST_LE       = 19'b000_0100_0000_0000_0000,
      ST_LF       = 19'b000_1000_0000_0000_0000,
      ST_LG       = 19'b001_0000_0000_0000_0000,
      ST_TIME_DIV = 19'b010_0000_0000_0000_0000,
      ST_DONE     = 19'b100_0000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   req_type              item_ff, item_in;
   logic [CHARGE_W-1:0]  charge_ff, charge_in;
   logic [TICKS_W-1:0]   mticks_ff, mticks_in;
   logic [TICKS_W-1:0]   sticks_ff, sticks_in;
   logic                 mode_ff, mode_in;
   logic [LEFT_W-1:0]    left_ff, left_in;
   logic [SPEED_W-1:0]   speed_ff, speed_in;
   logic [CHARGE_W-1:0]  cap_j_ff, cap_j_in;
   logic [FSEC_W-1:0]    fsec_ff, fsec_in;
   logic [WATT_W-1:0]    mw_ff, mw_in;
   logic [WATT_W-1:0]    sw_ff, sw_in;
   logic [PCT_W-1:0]     pct_ff, pct_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic [TOTAL_W+7:0]   t_ff, t_in;
   logic [DIV_NUM_W-1:0] acc_ff, acc_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   prod;
   div_ctrl_type         div_ctrl;
   div_stat_type         div_stat;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_quo;
   logic                 div_free;

   logic [WATT_W-1:0]    mw_div, sw_div;
   logic [TOTAL_W-1:0]   total;
   logic                 even_share;
   logic [DRAIN_W-1:0]   drain;
   logic [FSEC_W-1:0]    f_left;
   logic [CHARGE_W-1:0]  cap_new;
   logic [MIN_W-1:0]     min_nz;

   assign mw_div     = (mw_ff == '0) ? WATT_W'(1) : mw_ff;
   assign sw_div     = (sw_ff == '0) ? WATT_W'(1) : sw_ff;
   assign total      = TOTAL_W'(mticks_ff) + TOTAL_W'(sticks_ff);
   assign even_share = (total == '0) || ({mticks_ff, 1'b0} < total);
   assign drain      = DRAIN_W'(item_ff.moving ? mw_ff : sw_ff) * DRAIN_W'(TICK_SECONDS);
   assign f_left     = fsec_ff - left_ff;
   assign cap_new    = CHARGE_W'(csr_wdata[CAP_WH_W-1:0]) * CHARGE_W'(JOULES_PER_WH);
   assign min_nz     = (csr_wdata[MIN_W-1:0] == '0) ? MIN_W'(1) : csr_wdata[MIN_W-1:0];
   assign div_free   = !div_stat.busy && !div_stat.done;

   bce_mult u_mult (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   bce_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .num      (div_num),
      .den      (div_den),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      charge_in    = charge_ff;
      mticks_in    = mticks_ff;
      sticks_in    = sticks_ff;
      mode_in      = mode_ff;
      left_in      = left_ff;
      speed_in     = speed_ff;
      cap_j_in     = cap_j_ff;
      fsec_in      = fsec_ff;
      mw_in        = mw_ff;
      sw_in        = sw_ff;
      pct_in       = pct_ff;
      dist_in      = dist_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      den_in       = den_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a        = '0;
      mul_b        = '0;
      div_ctrl     = '0;
      div_num      = '0;
      div_den      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_PCT_MUL;
            case (item_ff.command)
               CMD_TICK: begin
                  if (mode_ff) begin
                     if (left_ff >= fsec_ff) begin
                        charge_in = '0;
                     end else begin
                        mul_a    = MUL_A_W'(f_left);
                        mul_b    = cap_j_ff;
                        state_in = ST_CHG_DIV;
                     end
                  end else begin
                     charge_in = (charge_ff > CHARGE_W'(drain)) ?
                                 charge_ff - CHARGE_W'(drain) : '0;
                     if (item_ff.moving) begin
                        if (mticks_ff != '1) mticks_in = mticks_ff + 1'b1;
                     end else begin
                        if (sticks_ff != '1) sticks_in = sticks_ff + 1'b1;
                     end
                  end
               end
               CMD_CHG_START: mode_in = 1'b1;
               CMD_CHG_REPORT: begin
                  left_in = item_ff.remaining_charge_seconds;
                  if (item_ff.remaining_charge_seconds == '0) begin
                     charge_in = cap_j_ff;
                     mode_in   = 1'b0;
                  end
               end
               CMD_SPEED: begin
                  speed_in = (item_ff.avg_speed_mm_s > SPEED_W'(SPEED_FLOOR)) ?
                             item_ff.avg_speed_mm_s : SPEED_W'(SPEED_FLOOR);
               end
               default: ;
            endcase
         end
         ST_CHG_DIV: begin
            div_ctrl.start = div_free;
            div_ctrl.steps = DIV_CNT_W'(CHG_STEPS);
            div_num        = DIV_NUM_W'(prod[CHG_STEPS-1:0]) << (DIV_NUM_W - CHG_STEPS);
            div_den        = DIV_DEN_W'(fsec_ff);
            if (div_stat.done) begin
               charge_in = div_quo[CHARGE_W-1:0];
               state_in  = ST_PCT_MUL;
            end
         end
         ST_PCT_MUL: begin
            mul_a    = MUL_A_W'(PCT_MAX);
            mul_b    = charge_ff;
            state_in = ST_PCT_DIV;
         end
         ST_PCT_DIV: begin
            div_ctrl.start = div_free && (cap_j_ff != '0);
            div_ctrl.steps = DIV_CNT_W'(PCT_STEPS);
            div_num        = DIV_NUM_W'(prod[PCT_STEPS-1:0]) << (DIV_NUM_W - PCT_STEPS);
            div_den        = DIV_DEN_W'(cap_j_ff);
            if (cap_j_ff == '0) begin
               pct_in   = '0;
               state_in = ST_DIST_MUL;
            end else if (div_stat.done) begin
               pct_in   = (div_quo > DIV_NUM_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) :
                          div_quo[PCT_W-1:0];
               state_in = ST_DIST_MUL;
            end
         end
         ST_DIST_MUL: begin
            mul_a    = MUL_A_W'(speed_ff);
            mul_b    = charge_ff;
            state_in = ST_DIST_DIV;
         end
         ST_DIST_DIV: begin
            div_ctrl.start = div_free;
            div_ctrl.steps = DIV_CNT_W'(DIST_STEPS);
            div_num        = DIV_NUM_W'(prod[DIST_STEPS-1:0]) << (DIV_NUM_W - DIST_STEPS);
            div_den        = DIV_DEN_W'(mw_div);
            if (div_stat.done) begin
               dist_in  = div_quo[DIST_W-1:0];
               state_in = ST_TIME_SEL;
            end
         end
         ST_TIME_SEL: begin
            if (even_share) begin
               mul_a    = MUL_A_W'(mw_div);
               mul_b    = MUL_B_W'(sw_div);
               state_in = ST_SA;
            end else begin
               mul_a    = MUL_A_W'(mticks_ff);
               mul_b    = MUL_B_W'(sw_div);
               state_in = ST_LA;
            end
         end
         ST_SA: begin
            den_in   = DIV_DEN_W'({prod[2*WATT_W-1:0], 1'b0});
            mul_a    = MUL_A_W'(MUL_A_W'(mw_div) + MUL_A_W'(sw_div));
            mul_b    = charge_ff;
            state_in = ST_SB;
         end
         ST_SB: begin
            acc_in   = DIV_NUM_W'(prod[CHARGE_W+WATT_W:0]);
            state_in = ST_TIME_DIV;
         end
         ST_LA: begin
            t_in     = (TOTAL_W+8)'(prod[TICKS_W+WATT_W-1:0]);
            mul_a    = MUL_A_W'(sticks_ff);
            mul_b    = MUL_B_W'(mw_div);
            state_in = ST_LB;
         end
         ST_LB: begin
            t_in     = t_ff + (TOTAL_W+8)'(prod[TICKS_W+WATT_W-1:0]);
            state_in = ST_LC;
         end
         ST_LC: begin
            mul_a    = MUL_A_W'(t_ff[SPLIT-1:0]);
            mul_b    = charge_ff;
            state_in = ST_LD;
         end
         ST_LD: begin
            acc_in   = DIV_NUM_W'(prod[CHARGE_W+SPLIT-1:0]);
            mul_a    = MUL_A_W'(t_ff[TOTAL_W+7:SPLIT]);
            mul_b    = charge_ff;
            state_in = ST_LE;
         end
         ST_LE: begin
            acc_in   = acc_ff + (DIV_NUM_W'(prod[CHARGE_W+SPLIT-1:0]) << SPLIT);
            mul_a    = MUL_A_W'(mw_div);
            mul_b    = MUL_B_W'(sw_div);
            state_in = ST_LF;
         end
         ST_LF: begin
            mul_a    = total;
            mul_b    = MUL_B_W'(prod[2*WATT_W-1:0]);
            state_in = ST_LG;
         end
         ST_LG: begin
            den_in   = prod[DIV_DEN_W-1:0];
            state_in = ST_TIME_DIV;
         end
         ST_TIME_DIV: begin
            div_ctrl.start = div_free;
            div_ctrl.steps = DIV_CNT_W'(TIME_STEPS);
            div_num        = acc_ff << (DIV_NUM_W - TIME_STEPS);
            div_den        = den_ff;
            if (div_stat.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.percent               = pct_ff;
               rsp_data_in.remaining_distance_mm = dist_ff;
               rsp_data_in.remaining_time_s      = div_quo[TIME_W-1:0];
               rsp_data_in.is_charging           = mode_ff;
               rsp_valid_in                      = 1'b1;
               state_in                          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: begin
               cap_j_in  = cap_new;
               charge_in = cap_new;
            end
            CSR_MOVING_W:     mw_in   = csr_wdata[WATT_W-1:0];
            CSR_STANDING_W:   sw_in   = csr_wdata[WATT_W-1:0];
            CSR_FULL_MINUTES: fsec_in = FSEC_W'(min_nz) * FSEC_W'(SECONDS_PER_MIN);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         charge_ff    <= CHARGE_W'(CAP_WH_RESET * JOULES_PER_WH);
         mticks_ff    <= '0;
         sticks_ff    <= '0;
         mode_ff      <= 1'b0;
         left_ff      <= '0;
         speed_ff     <= SPEED_W'(SPEED_FLOOR);
         cap_j_ff     <= CHARGE_W'(CAP_WH_RESET * JOULES_PER_WH);
         fsec_ff      <= FSEC_W'(MIN_RESET * SECONDS_PER_MIN);
         mw_ff        <= WATT_W'(MW_RESET);
         sw_ff        <= WATT_W'(SW_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         charge_ff    <= charge_in;
         mticks_ff    <= mticks_in;
         sticks_ff    <= sticks_in;
         mode_ff      <= mode_in;
         left_ff      <= left_in;
         speed_ff     <= speed_in;
         cap_j_ff     <= cap_j_in;
         fsec_ff      <= fsec_in;
         mw_ff        <= mw_in;
         sw_ff        <= sw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pct_ff      <= pct_in;
      dist_ff     <= dist_in;
      t_ff        <= t_in;
      acc_ff      <= acc_in;
      den_ff      <= den_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pct_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.percent <= PCT_W'(PCT_MAX)))
      else $error("percent above full scale");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after accepting a word");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result presented outside the done step");

endmodule

[sv/bce_mult.sv]
// ----------------------------------------------------------------------------
// bce_mult
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module bce_mult (
   input  logic                         clock,
   input  logic [bce_pkg::MUL_A_W-1:0]  mul_a,
   input  logic [bce_pkg::MUL_B_W-1:0]  mul_b,
   output logic [bce_pkg::MUL_P_W-1:0]  prod
);
   import bce_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[sv/bce_divider.sv]
// ----------------------------------------------------------------------------
// bce_divider
// Restoring divider, one quotient bit per cycle. The numerator arrives
// left-aligned; steps gives how many of its top bits to consume.
// ----------------------------------------------------------------------------
module bce_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  bce_pkg::div_ctrl_type         ctrl,
   input  logic [bce_pkg::DIV_NUM_W-1:0] num,
   input  logic [bce_pkg::DIV_DEN_W-1:0] den,
   output bce_pkg::div_stat_type         stat,
   output logic [bce_pkg::DIV_NUM_W-1:0] quotient
);
   import bce_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         num_in  = num;
         den_in  = den;
         quo_in  = '0;
         cnt_in  = ctrl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         num_in = num_ff << 1;
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

[tb/battery_charge_estimator_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_charge_estimator_core_test
// Self-checking regression for the battery charge estimator core. A local
// fuel gauge model predicts percent, remaining distance, remaining time and
// the charging flag for every accepted request word. Directed words come
// first, then charging sessions and random words under several register
// settings. The sender runs in bursts and the receiver stalls on its own.
// ----------------------------------------------------------------------------
module battery_charge_estimator_core_test;
   import bce_pkg::*;

   localparam int LEFT_MAX  = (1 << LEFT_W) - 1;
   localparam int SPEED_MAX = (1 << SPEED_W) - 1;
   localparam int CSR_MAX   = (1 << CSR_DATA_W) - 1;
   localparam int PHASES    = 6;

   class charge_scoreboard;
      logic [CAP_WH_W-1:0] cap_wh;
      logic [WATT_W-1:0]   mw;
      logic [WATT_W-1:0]   sw;
      logic [MIN_W-1:0]    minutes;
      logic [CHARGE_W-1:0] charge;
      logic [TICKS_W-1:0]  mov_ticks;
      logic [TICKS_W-1:0]  stand_ticks;
      logic                charging;
      logic [LEFT_W-1:0]   left;
      logic [SPEED_W-1:0]  speed;
      rsp_type             want_q[$];
      int                  failures;
      int                  results_seen;

      function void load_reset_state();
         cap_wh      = CAP_WH_W'(CAP_WH_RESET);
         mw          = WATT_W'(MW_RESET);
         sw          = WATT_W'(SW_RESET);
         minutes     = MIN_W'(MIN_RESET);
         charge      = CHARGE_W'(64'(cap_wh) * JOULES_PER_WH);
         mov_ticks   = '0;
         stand_ticks = '0;
         charging    = 1'b0;
         left        = '0;
         speed       = SPEED_W'(SPEED_FLOOR);
      endfunction

      function bit [63:0] full_seconds();
         return ((minutes == 0) ? 64'd1 : 64'(minutes)) * SECONDS_PER_MIN;
      endfunction

      function int unsigned pending();
         return want_q.size();
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CAPACITY: begin
               cap_wh = data[CAP_WH_W-1:0];
               charge = CHARGE_W'(64'(cap_wh) * JOULES_PER_WH);
            end
            CSR_MOVING_W:     mw = data[WATT_W-1:0];
            CSR_STANDING_W:   sw = data[WATT_W-1:0];
            CSR_FULL_MINUTES: minutes = data[MIN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_word(req_type w);
         bit [63:0] cap_j, mwd, swd, fsec, drain, total, pct, dist_mm, tim;
         rsp_type   r;
         cap_j = 64'(cap_wh) * JOULES_PER_WH;
         mwd   = (mw == 0) ? 64'd1 : 64'(mw);
         swd   = (sw == 0) ? 64'd1 : 64'(sw);
         case (cmd_type'(w.command))
            CMD_TICK: begin
               if (charging) begin
                  fsec = full_seconds();
                  if (64'(left) >= fsec) charge = '0;
                  else charge = CHARGE_W'(cap_j * (fsec - 64'(left)) / fsec);
               end else begin
                  drain = 64'(w.moving ? mw : sw) * TICK_SECONDS;
                  charge = (64'(charge) > drain) ? CHARGE_W'(64'(charge) - drain) : '0;
                  if (w.moving) begin
                     if (mov_ticks != '1) mov_ticks++;
                  end else if (stand_ticks != '1) begin
                     stand_ticks++;
                  end
               end
            end
            CMD_CHG_START: charging = 1'b1;
            CMD_CHG_REPORT: begin
               left = w.remaining_charge_seconds;
               if (left == 0) begin
                  charge   = CHARGE_W'(cap_j);
                  charging = 1'b0;
               end
            end
            default: speed = (w.avg_speed_mm_s > SPEED_FLOOR) ? w.avg_speed_mm_s
                                                               : SPEED_W'(SPEED_FLOOR);
         endcase

         if (cap_j == 0) begin
            pct = '0;
         end else begin
            pct = 64'(charge) * PCT_MAX / cap_j;
            if (pct > PCT_MAX) pct = 64'(PCT_MAX);
         end
         dist_mm = 64'(speed) * 64'(charge) / mwd;
         total   = 64'(mov_ticks) + 64'(stand_ticks);
         if (total == 0 || 64'd2 * 64'(mov_ticks) < total)
            tim = 64'(charge) * (swd + mwd) / (64'd2 * mwd * swd);
         else
            tim = 64'(charge) * (64'(mov_ticks) * swd + 64'(stand_ticks) * mwd)
                  / (total * mwd * swd);

         r.percent               = PCT_W'(pct);
         r.remaining_distance_mm = DIST_W'(dist_mm);
         r.remaining_time_s      = TIME_W'(tim);
         r.is_charging           = charging;
         want_q.push_back(r);
      endfunction

      function void log_failure(string msg);
         failures++;
         if (failures <= 10) $display("[%0t] mismatch: %s", $time, msg);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (want_q.size() == 0) begin
            log_failure($sformatf({"result %0d with none outstanding",
                        " (pct %0d dist %0d time %0d chg %0b)"},
                        results_seen, got.percent, got.remaining_distance_mm,
                        got.remaining_time_s, got.is_charging));
            return;
         end
         want = want_q.pop_front();
         if (got.percent !== want.percent ||
             got.remaining_distance_mm !== want.remaining_distance_mm ||
             got.remaining_time_s !== want.remaining_time_s ||
             got.is_charging !== want.is_charging)
            log_failure($sformatf({"result %0d: pct %0d/%0d dist %0d/%0d time %0d/%0d",
                        " chg %0b/%0b (expected/actual)"}, results_seen,
                        want.percent, got.percent,
                        want.remaining_distance_mm, got.remaining_distance_mm,
                        want.remaining_time_s, got.remaining_time_s,
                        want.is_charging, got.is_charging));
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   charge_scoreboard gauge_model = new;
   int  words_sent   = 0;
   int  hold_left    = 0;
   int  seg_left     = 0;
   int  seg_mode     = 0;
   bit  hold_pending = 1'b0;

   battery_charge_estimator_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // receiver: check, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) gauge_model.check_result(rsp_data);
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = 1500;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(16, 160);
            seg_mode = $urandom_range(0, 3);
         end
         seg_left--;
         case (seg_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 9) < 7);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (seg_left % 3 == 0);
         endcase
      end
   end

   function automatic req_type make_word(cmd_type c, bit mv, int unsigned left, int unsigned spd);
      req_type w;
      w.command                  = c;
      w.moving                   = mv;
      w.remaining_charge_seconds = LEFT_W'(left);
      w.avg_speed_mm_s           = SPEED_W'(spd);
      return w;
   endfunction

   function automatic req_type random_word(int mov_pct);
      int unsigned pick, fsec, left, spd;
      cmd_type     c;
      pick = $urandom_range(0, 99);
      fsec = 32'(gauge_model.full_seconds());
      left = $urandom_range(0, LEFT_MAX);
      spd  = $urandom_range(0, SPEED_MAX);
      if (pick < 50) begin
         c = CMD_TICK;
      end else if (pick < 58) begin
         c = CMD_CHG_START;
      end else if (pick < 75) begin
         c = CMD_CHG_REPORT;
         case ($urandom_range(0, 2))
            0: left = 0;
            1: left = $urandom_range(1, fsec);
            default: ;
         endcase
      end else begin
         c = CMD_SPEED;
         if ($urandom_range(0, 2) == 0) spd = $urandom_range(0, 300);
      end
      return make_word(c, $urandom_range(0, 99) < mov_pct, left, spd);
   endfunction

   // start, a few report and tick rounds, usually a closing report of zero
   function automatic void add_charging_session(ref req_type plan[$], input int mov_pct);
      int unsigned fsec, rounds, k, left;
      fsec = 32'(gauge_model.full_seconds());
      plan.push_back(make_word(CMD_CHG_START, 1'($urandom_range(0, 1)),
                               $urandom_range(0, LEFT_MAX), $urandom_range(0, SPEED_MAX)));
      rounds = $urandom_range(1, 4);
      for (k = 0; k < rounds; k++) begin
         left = ($urandom_range(0, 5) == 0) ? $urandom_range(fsec, LEFT_MAX)
                                            : $urandom_range(1, fsec - 1);
         plan.push_back(make_word(CMD_CHG_REPORT, 1'($urandom_range(0, 1)), left,
                                  $urandom_range(0, SPEED_MAX)));
         repeat ($urandom_range(1, 2))
            plan.push_back(make_word(CMD_TICK, $urandom_range(0, 99) < mov_pct,
                                     $urandom_range(0, LEFT_MAX), $urandom_range(0, SPEED_MAX)));
      end
      if ($urandom_range(0, 99) < 85)
         plan.push_back(make_word(CMD_CHG_REPORT, 1'($urandom_range(0, 1)), 0,
                                  $urandom_range(0, SPEED_MAX)));
   endfunction

   task automatic send_word(input req_type w, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      gauge_model.note_word(w);
      words_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (gauge_model.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int v);
      logic [CSR_DATA_W-1:0] data;
      data = (v < 0) ? CSR_DATA_W'($urandom_range(0, CSR_MAX)) : CSR_DATA_W'(v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      gauge_model.write_register(idx, data);
   endtask

   task automatic run_phase(input int count, input int mov_pct);
      req_type plan[$];
      int      sent, burst_left, gap;
      sent       = 0;
      burst_left = 0;
      while (sent < count) begin
         if (plan.size() == 0) begin
            if ($urandom_range(0, 4) == 0) add_charging_session(plan, mov_pct);
            else plan.push_back(random_word(mov_pct));
         end
         gap = 0;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
         end
         burst_left--;
         send_word(plan.pop_front(), gap);
         sent++;
      end
   endtask

   initial begin : stimulus
      req_type opening[$];
      int      cfg [PHASES][5] = '{'{1, 255, 255, 1, 70},
                                   '{2047, 1, 1, 2047, 30},
                                   '{0, 0, 0, 0, 80},
                                   '{-1, -1, -1, -1, 20},
                                   '{1000, 200, 3, 1440, 90},
                                   '{-1, -1, -1, -1, 60}};
      int      ph;
      gauge_model.load_reset_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      opening.push_back(make_word(CMD_SPEED, 1, LEFT_MAX, 0));
      opening.push_back(make_word(CMD_SPEED, 0, 0, SPEED_FLOOR));
      opening.push_back(make_word(CMD_SPEED, 0, 0, SPEED_FLOOR + 1));
      opening.push_back(make_word(CMD_SPEED, 1, 0, SPEED_MAX));
      opening.push_back(make_word(CMD_TICK, 0, 0, 0));
      opening.push_back(make_word(CMD_TICK, 1, 0, 0));
      opening.push_back(make_word(CMD_TICK, 1, 0, 0));
      opening.push_back(make_word(CMD_CHG_REPORT, 0, LEFT_MAX, 0));
      opening.push_back(make_word(CMD_CHG_START, 1, LEFT_MAX, SPEED_MAX));
      opening.push_back(make_word(CMD_TICK, 0, 0, 0));
      opening.push_back(make_word(CMD_CHG_REPORT, 0, 3600, 0));
      opening.push_back(make_word(CMD_TICK, 1, 0, 0));
      opening.push_back(make_word(CMD_CHG_REPORT, 1, 7199, 0));
      opening.push_back(make_word(CMD_TICK, 0, 0, 0));
      opening.push_back(make_word(CMD_CHG_START, 0, 0, 0));
      opening.push_back(make_word(CMD_CHG_REPORT, 0, 0, SPEED_MAX));
      opening.push_back(make_word(CMD_TICK, 1, 0, 0));
      opening.push_back(make_word(CMD_CHG_REPORT, 1, 0, 0));
      opening.push_back(make_word(CMD_SPEED, 0, 0, 12345));
      opening.push_back(make_word(CMD_TICK, 0, 0, 0));
      opening.push_back(make_word(CMD_TICK, 1, LEFT_MAX, SPEED_MAX));
      opening.push_back(make_word(CMD_CHG_START, 0, 0, 0));
      opening.push_back(make_word(CMD_TICK, 0, LEFT_MAX, SPEED_MAX));
      opening.push_back(make_word(CMD_CHG_REPORT, 0, 0, 0));
      foreach (opening[i]) send_word(opening[i], $urandom_range(0, 3));

      for (ph = 0; ph < PHASES; ph++) begin
         wait_for_results();
         write_csr(CSR_CAPACITY, cfg[ph][0]);
         write_csr(CSR_MOVING_W, cfg[ph][1]);
         write_csr(CSR_STANDING_W, cfg[ph][2]);
         write_csr(CSR_FULL_MINUTES, cfg[ph][3]);
         csr_we <= 1'b0;
         if (ph == 4) hold_pending = 1'b1;
         run_phase(75, cfg[ph][4]);
      end
      wait_for_results();
      repeat (300) @(posedge clock);

      if (gauge_model.pending() != 0) gauge_model.failures += gauge_model.pending();
      $display("covered %0d words (ticks, charging sessions, speed reports) over %0d settings",
               words_sent, PHASES + 1);
      $display("%0d results checked, %0d failures, one long output stall", 
               gauge_model.results_seen, gauge_model.failures);
      if (gauge_model.failures == 0)
         $display("battery_charge_estimator_core regression: pass");
      else
         $display("battery_charge_estimator_core regression: fail");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("battery_charge_estimator_core regression: fail");
      $finish;
   end

endmodule
